// ===== rtl/core/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants and control types of the three-level cache read block.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int ADDR_W = 10;
    localparam int DATA_W = 32;

    localparam int DEF_WORDS_PER_BLOCK = 4;
    localparam int DEF_L1_MAX_LINES    = 16;
    localparam int DEF_L2_MAX_LINES    = 32;
    localparam int DEF_L3_MAX_LINES    = 64;
    localparam int DEF_MEMORY_DEPTH    = 1024;
    localparam int DEF_AGE_BITS        = 16;

    localparam int L1_RAW_W = 5;
    localparam int L2_RAW_W = 6;
    localparam int L3_RAW_W = 7;

    localparam logic [L1_RAW_W-1:0] L1_LINES_RST = 5'd16;
    localparam logic [L2_RAW_W-1:0] L2_LINES_RST = 6'd32;
    localparam logic [L3_RAW_W-1:0] L3_LINES_RST = 7'd64;

    localparam logic [1:0] REG_L1_LINES = 2'd0;
    localparam logic [1:0] REG_L2_LINES = 2'd1;
    localparam logic [1:0] REG_L3_LINES = 2'd2;

    localparam logic [1:0] HIT_L1  = 2'd0;
    localparam logic [1:0] HIT_L2  = 2'd1;
    localparam logic [1:0] HIT_L3  = 2'd2;
    localparam logic [1:0] HIT_MEM = 2'd3;

    typedef struct packed {
        logic scan;
        logic touch;
        logic fill;
        logic wr;
    } t_lvl_ctl;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_lvl_stat;

endpackage

// ===== rtl/core/tlc_div.sv =====
// ----------------------------------------------------------------------------
// tlc_div
// Remainder by a constant divisor, computed combinationally by reciprocal
// multiplication followed by a multiply back and a subtract.
// ----------------------------------------------------------------------------
module tlc_div #(
    parameter int NW      = 10,
    parameter int DIVISOR = 4
) (
    input  logic [NW-1:0] i_dividend,
    output logic [NW-1:0] o_rem
);
    localparam int     LW    = $clog2(DIVISOR);
    localparam int     SH    = NW + LW;
    localparam int     MW    = NW + 1;
    localparam int     PW    = NW + MW;
    localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1)
                             / longint'(DIVISOR);

    logic [PW-1:0] prod;
    logic [NW-1:0] quot;

    assign prod  = PW'(i_dividend) * PW'(RECIP);
    assign quot  = NW'(prod >> SH);
    assign o_rem = i_dividend - NW'(quot * NW'(DIVISOR));
endmodule

// ===== rtl/core/tlc_backing.sv =====
// ----------------------------------------------------------------------------
// tlc_backing
// Backing word memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tlc_backing #(
    parameter int MEMORY_DEPTH = tlc_pkg::DEF_MEMORY_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(MEMORY_DEPTH)-1:0] i_waddr,
    input  logic [tlc_pkg::DATA_W-1:0]      i_wdata,
    input  logic [$clog2(MEMORY_DEPTH)-1:0] i_raddr,
    output logic [tlc_pkg::DATA_W-1:0]      o_rdata
);
    import tlc_pkg::*;

    logic [DATA_W-1:0] r_mem [MEMORY_DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/core/tlc_level.sv =====
// ----------------------------------------------------------------------------
// tlc_level
// One fully associative cache level: tag and age memory scanned one line
// per cycle, valid bits in flops, and a block data memory.
// ----------------------------------------------------------------------------
module tlc_level #(
    parameter int LINES    = 16,
    parameter int WPB      = 4,
    parameter int AGE_BITS = 16,
    parameter int RAW_W    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlc_pkg::t_lvl_ctl           i_ctl,
    input  logic [RAW_W-1:0]            i_lines,
    input  logic [tlc_pkg::ADDR_W-1:0]  i_tag,
    input  logic [$clog2(WPB)-1:0]      i_word_sel,
    input  logic [tlc_pkg::DATA_W-1:0]  i_wdata,
    output logic [tlc_pkg::DATA_W-1:0]  o_rdata,
    output tlc_pkg::t_lvl_stat          o_stat
);
    import tlc_pkg::*;

    localparam int IW  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CW  = $clog2(LINES + 1);
    localparam int DAW = $clog2(LINES * WPB);
    localparam int TW  = ADDR_W + AGE_BITS;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TOUCH} t_state;

    t_state              r_state;
    logic [CW-1:0]       cnt;
    logic [CW-1:0]       r_ptr;
    logic                issue;
    logic                r_ret_vld;
    logic [IW-1:0]       r_ret_idx;
    logic [LINES-1:0]    r_valid;
    logic [TW-1:0]       r_ta_mem [LINES];
    logic [TW-1:0]       r_ta_q;
    logic [DATA_W-1:0]   r_dat_mem [LINES*WPB];
    logic [DATA_W-1:0]   r_dat_q;
    logic                r_found;
    logic [IW-1:0]       r_hit_idx;
    logic                r_have_inv;
    logic [IW-1:0]       r_inv_idx;
    logic                r_max_set;
    logic [AGE_BITS-1:0] r_max_age;
    logic [IW-1:0]       r_max_idx;
    logic [IW-1:0]       victim;
    logic [ADDR_W-1:0]   q_tag;
    logic [AGE_BITS-1:0] q_age;
    logic [AGE_BITS-1:0] new_age;
    logic                ta_we;
    logic [IW-1:0]       ta_waddr;
    logic [TW-1:0]       ta_wdata;

    always_comb begin
        if (i_lines == '0) begin
            cnt = CW'(1);
        end else if (32'(i_lines) > LINES) begin
            cnt = CW'(LINES);
        end else begin
            cnt = CW'(i_lines);
        end
    end

    assign issue  = (r_state != S_IDLE) && (r_ptr < cnt);
    assign victim = r_have_inv ? r_inv_idx : r_max_idx;
    assign q_tag  = r_ta_q[TW-1:AGE_BITS];
    assign q_age  = r_ta_q[AGE_BITS-1:0];

    always_comb begin
        if (r_ret_idx == r_hit_idx) begin
            new_age = '0;
        end else if (q_age == '1) begin
            new_age = q_age;
        end else begin
            new_age = q_age + 1'b1;
        end
        ta_we    = 1'b0;
        ta_waddr = victim;
        ta_wdata = {i_tag, {AGE_BITS{1'b0}}};
        if (i_ctl.fill) begin
            ta_we = 1'b1;
        end else if (r_state == S_TOUCH && r_ret_vld && r_valid[r_ret_idx]) begin
            ta_we    = 1'b1;
            ta_waddr = r_ret_idx;
            ta_wdata = {q_tag, new_age};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ta_we) begin
            r_ta_mem[ta_waddr] <= ta_wdata;
        end
        r_ta_q <= r_ta_mem[r_ptr[IW-1:0]];
        if (i_ctl.wr) begin
            r_dat_mem[DAW'(victim) * DAW'(WPB) + DAW'(i_word_sel)] <= i_wdata;
        end
        r_dat_q <= r_dat_mem[DAW'(r_hit_idx) * DAW'(WPB) + DAW'(i_word_sel)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_ret_vld <= 1'b0;
            r_ptr     <= '0;
            r_found   <= 1'b0;
        end else begin
            r_ret_vld <= issue;
            r_ret_idx <= r_ptr[IW-1:0];
            if (issue) begin
                r_ptr <= r_ptr + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.scan) begin
                        r_state    <= S_SCAN;
                        r_ptr      <= '0;
                        r_found    <= 1'b0;
                        r_have_inv <= 1'b0;
                        r_max_set  <= 1'b0;
                    end else if (i_ctl.touch) begin
                        r_state <= S_TOUCH;
                        r_ptr   <= '0;
                    end
                end
                S_SCAN, S_TOUCH: begin
                    if (!issue && !r_ret_vld) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_SCAN && r_ret_vld) begin
                if (r_valid[r_ret_idx] && q_tag == i_tag && !r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_ret_idx;
                end
                if (!r_valid[r_ret_idx] && !r_have_inv) begin
                    r_have_inv <= 1'b1;
                    r_inv_idx  <= r_ret_idx;
                end
                if (!r_max_set || q_age > r_max_age) begin
                    r_max_set <= 1'b1;
                    r_max_age <= q_age;
                    r_max_idx <= r_ret_idx;
                end
            end
            if (i_ctl.fill) begin
                r_valid[victim] <= 1'b1;
            end
        end
    end

    assign o_rdata     = r_dat_q;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.hit  = r_found;
endmodule

// ===== rtl/core/three_level_lru_cache_read.sv =====
// ----------------------------------------------------------------------------
// three_level_lru_cache_read
// Word reads through three fully associative LRU cache levels over a
// preloadable word memory.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A preload is written into the backing
// memory at the edge that accepts it, so preloads can follow back to back. A
// read first scans the tag and age memories of all three levels in parallel,
// one line per cycle. The level that hit is then aged. An L1 hit then presents
// its word from the L1 data memory. Any other read gathers the block from the
// level that hit or from memory, fills the levels that lack it and then
// presents the word. The block returns to idle before the next transaction is
// accepted. A finished result waits in an output register while the next
// transaction is accepted; a read that finishes while that register is still
// stalled holds in its last cycle.
// ----------------------------------------------------------------------------
module three_level_lru_cache_read #(
    parameter int WORDS_PER_BLOCK = tlc_pkg::DEF_WORDS_PER_BLOCK,
    parameter int L1_MAX_LINES    = tlc_pkg::DEF_L1_MAX_LINES,
    parameter int L2_MAX_LINES    = tlc_pkg::DEF_L2_MAX_LINES,
    parameter int L3_MAX_LINES    = tlc_pkg::DEF_L3_MAX_LINES,
    parameter int MEMORY_DEPTH    = tlc_pkg::DEF_MEMORY_DEPTH,
    parameter int AGE_BITS        = tlc_pkg::DEF_AGE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [tlc_pkg::ADDR_W-1:0]        i_word_address,
    input  logic signed [tlc_pkg::DATA_W-1:0] i_write_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [tlc_pkg::DATA_W-1:0] o_read_word,
    output logic [1:0]                        o_hit_level,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tlc_pkg::*;

    localparam int OW  = $clog2(WORDS_PER_BLOCK);
    localparam int KW  = $clog2(WORDS_PER_BLOCK + 1);
    localparam int MAW = $clog2(MEMORY_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_TOUCH, S_GATHER, S_FILL, S_FIN
    } t_state;

    t_state            r_state;
    logic [L1_RAW_W-1:0] r_l1_lines;
    logic [L2_RAW_W-1:0] r_l2_lines;
    logic [L3_RAW_W-1:0] r_l3_lines;
    logic [OW-1:0]     r_off;
    logic [ADDR_W-1:0] r_base;
    logic [MAW-1:0]    r_mbase;
    logic [1:0]        r_h;
    logic [KW-1:0]     r_ki;
    logic [KW-1:0]     r_kw;
    logic [OW-1:0]     r_kr;
    logic              r_rv;
    logic [DATA_W-1:0] r_buf [WORDS_PER_BLOCK];
    logic [DATA_W-1:0] r_word;
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_word;
    logic [1:0]        r_out_lvl;

    t_lvl_ctl          ctl1, ctl2, ctl3;
    t_lvl_stat         st1, st2, st3;
    logic [DATA_W-1:0] q1, q2, q3, mem_q;
    logic [OW-1:0]     sel;
    logic [ADDR_W-1:0] blk_rem, mod_in, mod_rem;
    logic              scan_done, lvl_busy, g_issue, cfg_wr, mem_we;
    logic [1:0]        hit_lvl;
    logic [MAW:0]      msum;
    logic [MAW-1:0]    mem_raddr;
    logic [DATA_W-1:0] src_q;

    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign lvl_busy  = st1.busy || st2.busy || st3.busy;
    assign scan_done = !lvl_busy;
    assign mem_we    = (r_state == S_IDLE) && i_valid && i_req_type;
    assign mod_in    = (r_state == S_IDLE) ? i_word_address : r_base;
    assign g_issue   = (r_state == S_GATHER) && (r_ki < KW'(WORDS_PER_BLOCK));
    assign msum      = (MAW + 1)'(r_mbase) + (MAW + 1)'(r_ki);
    assign mem_raddr = (msum >= (MAW + 1)'(MEMORY_DEPTH))
                     ? MAW'(msum - (MAW + 1)'(MEMORY_DEPTH)) : MAW'(msum);

    always_comb begin
        unique case (paddr[3:2])
            REG_L1_LINES: prdata = 32'(r_l1_lines);
            REG_L2_LINES: prdata = 32'(r_l2_lines);
            REG_L3_LINES: prdata = 32'(r_l3_lines);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        priority if (st1.hit) begin
            hit_lvl = HIT_L1;
        end else if (st2.hit) begin
            hit_lvl = HIT_L2;
        end else if (st3.hit) begin
            hit_lvl = HIT_L3;
        end else begin
            hit_lvl = HIT_MEM;
        end
    end

    always_comb begin
        unique case (r_h)
            HIT_L2:  src_q = q2;
            HIT_L3:  src_q = q3;
            default: src_q = mem_q;
        endcase
        if (r_state == S_GATHER) begin
            sel = r_ki[OW-1:0];
        end else if (r_state == S_FILL) begin
            sel = r_kw[OW-1:0];
        end else begin
            sel = r_off;
        end

        ctl1.scan  = (r_state == S_IDLE) && i_valid && !i_req_type;
        ctl2.scan  = ctl1.scan;
        ctl3.scan  = ctl1.scan;
        ctl1.touch = (r_state == S_SCAN) && scan_done && hit_lvl == HIT_L1;
        ctl2.touch = (r_state == S_SCAN) && scan_done && hit_lvl == HIT_L2;
        ctl3.touch = (r_state == S_SCAN) && scan_done && hit_lvl == HIT_L3;
        ctl1.wr    = (r_state == S_FILL) && !st1.hit;
        ctl2.wr    = (r_state == S_FILL) && !st2.hit;
        ctl3.wr    = (r_state == S_FILL) && !st3.hit;
        ctl1.fill  = ctl1.wr && r_kw == '0;
        ctl2.fill  = ctl2.wr && r_kw == '0;
        ctl3.fill  = ctl3.wr && r_kw == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_rv       <= 1'b0;
            r_l1_lines <= L1_LINES_RST;
            r_l2_lines <= L2_LINES_RST;
            r_l3_lines <= L3_LINES_RST;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_L1_LINES: r_l1_lines <= pwdata[L1_RAW_W-1:0];
                    REG_L2_LINES: r_l2_lines <= pwdata[L2_RAW_W-1:0];
                    REG_L3_LINES: r_l3_lines <= pwdata[L3_RAW_W-1:0];
                    default:      ;
                endcase
            end
            if (r_out_vld && !i_stall && r_state != S_FIN) begin
                r_out_vld <= 1'b0;
            end
            r_rv <= g_issue;
            r_kr <= r_ki[OW-1:0];
            if (g_issue) begin
                r_ki <= r_ki + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !i_req_type) begin
                        r_off   <= blk_rem[OW-1:0];
                        r_base  <= i_word_address - blk_rem;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_mbase <= MAW'(mod_rem);
                        r_h     <= hit_lvl;
                        r_ki    <= '0;
                        r_state <= (hit_lvl == HIT_MEM) ? S_GATHER : S_TOUCH;
                    end
                end
                S_TOUCH: begin
                    if (!lvl_busy) begin
                        r_state <= (r_h == HIT_L1) ? S_FIN : S_GATHER;
                    end
                end
                S_GATHER: begin
                    if (!g_issue && !r_rv) begin
                        r_kw    <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_kw <= r_kw + 1'b1;
                    if (r_kw == KW'(WORDS_PER_BLOCK - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_vld || !i_stall) begin
                        r_out_vld  <= 1'b1;
                        r_out_word <= (r_h == HIT_L1) ? q1 : r_word;
                        r_out_lvl  <= r_h;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GATHER && r_rv) begin
            r_buf[r_kr] <= src_q;
            if (r_kr == r_off) begin
                r_word <= src_q;
            end
        end
    end

    tlc_div #(.NW(ADDR_W), .DIVISOR(WORDS_PER_BLOCK)) u_blk (
        .i_dividend (i_word_address),
        .o_rem      (blk_rem)
    );

    tlc_div #(.NW(ADDR_W), .DIVISOR(MEMORY_DEPTH)) u_mod (
        .i_dividend (mod_in),
        .o_rem      (mod_rem)
    );

    tlc_backing #(.MEMORY_DEPTH(MEMORY_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (MAW'(mod_rem)),
        .i_wdata (i_write_word),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    tlc_level #(
        .LINES(L1_MAX_LINES), .WPB(WORDS_PER_BLOCK), .AGE_BITS(AGE_BITS), .RAW_W(L1_RAW_W)
    ) u_l1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl1), .i_lines(r_l1_lines),
        .i_tag(r_base), .i_word_sel(sel), .i_wdata(r_buf[r_kw[OW-1:0]]),
        .o_rdata(q1), .o_stat(st1)
    );

    tlc_level #(
        .LINES(L2_MAX_LINES), .WPB(WORDS_PER_BLOCK), .AGE_BITS(AGE_BITS), .RAW_W(L2_RAW_W)
    ) u_l2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl2), .i_lines(r_l2_lines),
        .i_tag(r_base), .i_word_sel(sel), .i_wdata(r_buf[r_kw[OW-1:0]]),
        .o_rdata(q2), .o_stat(st2)
    );

    tlc_level #(
        .LINES(L3_MAX_LINES), .WPB(WORDS_PER_BLOCK), .AGE_BITS(AGE_BITS), .RAW_W(L3_RAW_W)
    ) u_l3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl3), .i_lines(r_l3_lines),
        .i_tag(r_base), .i_word_sel(sel), .i_wdata(r_buf[r_kw[OW-1:0]]),
        .o_rdata(q3), .o_stat(st3)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_vld;
    assign o_read_word = r_out_word;
    assign o_hit_level = r_out_lvl;

    a_lvl_busy_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lvl_busy |-> o_stall)
        else $error("cache level active outside a transaction");

    a_l1_hit_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && st1.hit) |-> (r_h == HIT_L1))
        else $error("L1 hit reported from a lower level");

    a_no_gather_on_l1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATHER || r_state == S_FILL) |-> (r_h != HIT_L1 && !st1.hit))
        else $error("block fill started after an L1 hit");

endmodule
